[src/csvl_pkg.sv]
// Shared constants for the CSV record boundary lexer.
`default_nettype none
package csvl_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int SHOWN_WIDTH = 32;
    localparam int CNT_EXT_WIDTH = (COUNT_WIDTH > SHOWN_WIDTH) ? COUNT_WIDTH : SHOWN_WIDTH;

    localparam int STATE_WIDTH = 3;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 8;
    localparam int IN_DATA_WIDTH = 8;
    localparam int OUT_DATA_WIDTH = 40;

    localparam logic [STATE_WIDTH-1:0] LX_START    = 3'd0;
    localparam logic [STATE_WIDTH-1:0] LX_FIELD    = 3'd1;
    localparam logic [STATE_WIDTH-1:0] LX_ESC      = 3'd2;
    localparam logic [STATE_WIDTH-1:0] LX_QUOTED   = 3'd3;
    localparam logic [STATE_WIDTH-1:0] LX_QQUOTE   = 3'd4;
    localparam logic [STATE_WIDTH-1:0] LX_QESC     = 3'd5;
    localparam logic [STATE_WIDTH-1:0] LX_AFTER_CR = 3'd6;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUOTE_BYTE     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESCAPE_BYTE    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEPARATOR_BYTE = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLED_QUOTE  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUOTING        = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESCAPING       = 3'd5;

    localparam logic [7:0] RST_QUOTE_BYTE     = 8'd34;
    localparam logic [7:0] RST_ESCAPE_BYTE    = 8'd92;
    localparam logic [7:0] RST_SEPARATOR_BYTE = 8'd44;

endpackage
`default_nettype wire

[src/csv_record_boundary_lexer.sv]
// Top level of the CSV record boundary lexer: byte lexer, record counter and output register.
`default_nettype none
// The block takes one byte of CSV text per beat and returns one result beat per input
// beat, and it accepts a new byte in every cycle while the output register is empty or
// being drained. Each result is registered and appears in the cycle after its byte is taken;
// the seven-state lexer and the record counter update in that same cycle. The user sets the
// quote, escape and separator bytes and the three enables via the write port only while the
// stream is idle (not enforced). A held CR is resolved by the next byte, or at once on tlast.
module csv_record_boundary_lexer (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [csvl_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [csvl_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: [7:0] data_byte
    input  wire logic [csvl_pkg::IN_DATA_WIDTH-1:0]    s_axis_tdata,
    // tuser: [0] restart
    input  wire logic                                  s_axis_tuser,
    // tlast: chunk_end
    input  wire logic                                  s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tdata: [0] boundary_before, [3:1] lexer_state_after, [35:4] records_done, [39:36] zero
    output logic [csvl_pkg::OUT_DATA_WIDTH-1:0]        m_axis_tdata,
    // tlast: boundary_after
    output logic                                       m_axis_tlast
);
    import csvl_pkg::*;

    logic [7:0]             r_quote_byte;
    logic [7:0]             r_escape_byte;
    logic [7:0]             r_separator_byte;
    logic                   r_doubled_quote;
    logic                   r_quoting;
    logic                   r_escaping;

    logic [STATE_WIDTH-1:0] r_state;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [STATE_WIDTH-1:0] n_state;
    logic [COUNT_WIDTH-1:0] n_cnt;

    logic                   r_out_valid;
    logic                   r_out_before;
    logic                   r_out_after;
    logic [STATE_WIDTH-1:0] r_out_state;
    logic [SHOWN_WIDTH-1:0] r_out_count;
    logic [SHOWN_WIDTH-1:0] n_shown;

    logic [7:0]             b;
    logic                   accept;
    logic [STATE_WIDTH-1:0] st_in;
    logic [STATE_WIDTH-1:0] st_lex;
    logic [COUNT_WIDTH-1:0] cnt_base;
    logic [1:0]             inc;
    logic                   brk_before;
    logic                   after;
    logic                   cr_done;
    logic [STATE_WIDTH-1:0] u_state;
    logic                   u_rec;
    logic [COUNT_WIDTH:0]   cnt_sum;
    logic [CNT_EXT_WIDTH-1:0] cnt_ext;

    assign b = s_axis_tdata;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Unquoted lexing of the current byte, independent of the present state.
    always_comb begin
        u_state = LX_FIELD;
        u_rec = 1'b0;
        if (r_escaping && b == r_escape_byte) begin
            u_state = LX_ESC;
        end else if (b == CH_CR) begin
            if (s_axis_tlast) begin
                u_state = LX_START;
                u_rec = 1'b1;
            end else begin
                u_state = LX_AFTER_CR;
            end
        end else if (b == CH_LF) begin
            u_state = LX_START;
            u_rec = 1'b1;
        end else if (r_quoting && b == r_separator_byte) begin
            u_state = LX_START;
        end
    end

    always_comb begin
        st_in = s_axis_tuser ? LX_START : r_state;
        cnt_base = s_axis_tuser ? '0 : r_cnt;
        st_lex = st_in;
        brk_before = 1'b0;
        after = 1'b0;
        cr_done = 1'b0;
        inc = 2'd0;
        n_state = st_in;
        if (st_in == LX_AFTER_CR) begin
            if (b == CH_LF) begin
                n_state = LX_START;
                inc = 2'd1;
                after = 1'b1;
                cr_done = 1'b1;
            end else begin
                brk_before = 1'b1;
                inc = 2'd1;
                st_lex = LX_START;
            end
        end
        if (!cr_done) begin
            case (st_lex)
                LX_FIELD: begin
                    n_state = u_state;
                    after = u_rec;
                end
                LX_ESC: begin
                    n_state = LX_FIELD;
                end
                LX_QUOTED: begin
                    if (r_escaping && b == r_escape_byte) begin
                        n_state = LX_QESC;
                    end else if (b == r_quote_byte) begin
                        n_state = LX_QQUOTE;
                    end else begin
                        n_state = LX_QUOTED;
                    end
                end
                LX_QQUOTE: begin
                    if (r_doubled_quote && b == r_quote_byte) begin
                        n_state = LX_QUOTED;
                    end else begin
                        n_state = u_state;
                        after = u_rec;
                    end
                end
                LX_QESC: begin
                    n_state = LX_QUOTED;
                end
                default: begin
                    if (r_quoting && b == r_quote_byte) begin
                        n_state = LX_QUOTED;
                    end else begin
                        n_state = u_state;
                        after = u_rec;
                    end
                end
            endcase
            inc = inc + {1'b0, after};
        end
        cnt_sum = {1'b0, cnt_base} + (COUNT_WIDTH + 1)'(inc);
        if (cnt_sum[COUNT_WIDTH]) begin
            n_cnt = '1;
        end else begin
            n_cnt = cnt_sum[COUNT_WIDTH-1:0];
        end
        cnt_ext = CNT_EXT_WIDTH'(n_cnt);
        if (cnt_ext > CNT_EXT_WIDTH'({SHOWN_WIDTH{1'b1}})) begin
            n_shown = '1;
        end else begin
            n_shown = cnt_ext[SHOWN_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_byte <= RST_QUOTE_BYTE;
            r_escape_byte <= RST_ESCAPE_BYTE;
            r_separator_byte <= RST_SEPARATOR_BYTE;
            r_doubled_quote <= 1'b1;
            r_quoting <= 1'b1;
            r_escaping <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_QUOTE_BYTE:     r_quote_byte <= i_cfg_data;
                REG_ESCAPE_BYTE:    r_escape_byte <= i_cfg_data;
                REG_SEPARATOR_BYTE: r_separator_byte <= i_cfg_data;
                REG_DOUBLED_QUOTE:  r_doubled_quote <= i_cfg_data[0];
                REG_QUOTING:        r_quoting <= i_cfg_data[0];
                REG_ESCAPING:       r_escaping <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LX_START;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_cnt <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_before <= brk_before;
            r_out_after <= after;
            r_out_state <= n_state;
            r_out_count <= n_shown;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast = r_out_after;
    assign m_axis_tdata = {{(OUT_DATA_WIDTH - SHOWN_WIDTH - STATE_WIDTH - 1){1'b0}},
                           r_out_count, r_out_state, r_out_before};

endmodule
`default_nettype wire

[verif/csv_record_boundary_lexer_test.sv]
// Self-checking testbench for the CSV record boundary lexer with a byte-level lexing predictor.
`timescale 1ns / 1ps
module csv_record_boundary_lexer_test;
    import csvl_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_BEATS = 200;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       chunk_end;
    } text_beat_t;

    typedef struct packed {
        logic                   brk_before;
        logic                   brk_after;
        logic [STATE_WIDTH-1:0] state;
        logic [SHOWN_WIDTH-1:0] records;
    } lex_result_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   i_cfg_data = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_DATA_WIDTH-1:0]    s_axis_tdata = '0;
    logic                        s_axis_tuser = 1'b0;
    logic                        s_axis_tlast = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0]   m_axis_tdata;
    logic                        m_axis_tlast;

    csv_record_boundary_lexer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic [7:0] qt_char = RST_QUOTE_BYTE;
    logic [7:0] esc_char = RST_ESCAPE_BYTE;
    logic [7:0] sep_char = RST_SEPARATOR_BYTE;
    bit         dq_en = 1'b1;
    bit         quote_en = 1'b1;
    bit         esc_en = 1'b0;

    logic [STATE_WIDTH-1:0] lex_state = LX_START;
    logic [COUNT_WIDTH-1:0] rec_count = '0;

    text_beat_t  text_q[$];
    lex_result_t outcome_q[$];
    text_beat_t  held_beat;
    lex_result_t want;

    int idle_rate = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int beats_queued = 0;
    int mismatches = 0;
    int cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void bump_count();
        if (rec_count != '1) rec_count = rec_count + 1'b1;
    endfunction

    function automatic logic lex_plain(input logic [7:0] b, input logic last);
        lex_plain = 1'b0;
        if (esc_en && b == esc_char) begin
            lex_state = LX_ESC;
        end else if (b == CH_CR) begin
            if (last) begin
                lex_state = LX_START;
                bump_count();
                lex_plain = 1'b1;
            end else begin
                lex_state = LX_AFTER_CR;
            end
        end else if (b == CH_LF) begin
            lex_state = LX_START;
            bump_count();
            lex_plain = 1'b1;
        end else if (quote_en && b == sep_char) begin
            lex_state = LX_START;
        end else begin
            lex_state = LX_FIELD;
        end
    endfunction

    function automatic lex_result_t lex_step(input text_beat_t t);
        lex_result_t r;
        logic [CNT_EXT_WIDTH-1:0] wide;
        r = '0;
        if (t.restart) begin
            lex_state = LX_START;
            rec_count = '0;
        end
        if (lex_state == LX_AFTER_CR && t.data == CH_LF) begin
            lex_state = LX_START;
            bump_count();
            r.brk_after = 1'b1;
        end else begin
            if (lex_state == LX_AFTER_CR) begin
                r.brk_before = 1'b1;
                bump_count();
                lex_state = LX_START;
            end
            case (lex_state)
                LX_FIELD: r.brk_after = lex_plain(t.data, t.chunk_end);
                LX_ESC: lex_state = LX_FIELD;
                LX_QUOTED: begin
                    if (esc_en && t.data == esc_char) lex_state = LX_QESC;
                    else if (t.data == qt_char) lex_state = LX_QQUOTE;
                end
                LX_QQUOTE: begin
                    if (dq_en && t.data == qt_char) lex_state = LX_QUOTED;
                    else r.brk_after = lex_plain(t.data, t.chunk_end);
                end
                LX_QESC: lex_state = LX_QUOTED;
                default: begin
                    if (quote_en && t.data == qt_char) lex_state = LX_QUOTED;
                    else r.brk_after = lex_plain(t.data, t.chunk_end);
                end
            endcase
        end
        wide = CNT_EXT_WIDTH'(rec_count);
        r.state = lex_state;
        r.records = (wide > CNT_EXT_WIDTH'({SHOWN_WIDTH{1'b1}})) ? '1 : wide[SHOWN_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) outcome_q.push_back(lex_step(held_beat));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
                    src_gap = $urandom_range(0, 13);
                    s_axis_tvalid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    held_beat = text_q.pop_front();
                    s_axis_tdata <= held_beat.data;
                    s_axis_tuser <= held_beat.restart;
                    s_axis_tlast <= held_beat.chunk_end;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with no expectation pending");
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_axis_tdata[0] !== want.brk_before) begin
                        $error("boundary_before: expected %0d, got %0d",
                               want.brk_before, m_axis_tdata[0]);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.brk_after) begin
                        $error("boundary_after: expected %0d, got %0d",
                               want.brk_after, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tdata[3:1] !== want.state) begin
                        $error("lexer_state_after: expected %0d, got %0d",
                               want.state, m_axis_tdata[3:1]);
                        mismatches++;
                    end
                    if (m_axis_tdata[35:4] !== want.records) begin
                        $error("records_done: expected %0d, got %0d",
                               want.records, m_axis_tdata[35:4]);
                        mismatches++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
                sink_gap = $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_beat(input logic [7:0] d, input logic rs, input logic ce);
        text_beat_t t;
        t.data = d;
        t.restart = rs;
        t.chunk_end = ce;
        text_q.push_back(t);
        beats_queued++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [7:0] d);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
    endtask

    task automatic apply_config(input logic [7:0] q, input logic [7:0] e, input logic [7:0] s,
                                input bit dq, input bit qe, input bit ee);
        write_reg(REG_QUOTE_BYTE, q);
        write_reg(REG_ESCAPE_BYTE, e);
        write_reg(REG_SEPARATOR_BYTE, s);
        write_reg(REG_DOUBLED_QUOTE, {7'($urandom), dq});
        write_reg(REG_QUOTING, {7'($urandom), qe});
        write_reg(REG_ESCAPING, {7'($urandom), ee});
        write_reg(REG_ESCAPING + 1'b1, 8'($urandom));
        write_reg(REG_ESCAPING + 2'd2, 8'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        qt_char = q;
        esc_char = e;
        sep_char = s;
        dq_en = dq;
        quote_en = qe;
        esc_en = ee;
    endtask

    task automatic drain();
        while (text_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0: return qt_char;
            1: return esc_char;
            2: return sep_char;
            3: return CH_CR;
            4: return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] content_char();
        if ($urandom_range(0, 3) == 0) return pick_char();
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    task automatic push_record();
        int fields;
        int len;
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++) begin
            if (f != 0) push_beat(sep_char, 1'b0, 1'b0);
            len = $urandom_range(0, 5);
            if (quote_en && $urandom_range(0, 1) == 1) begin
                push_beat(qt_char, 1'b0, 1'b0);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            push_beat(qt_char, 1'b0, 1'b0);
                            push_beat(qt_char, 1'b0, 1'b0);
                        end
                        1: begin
                            if (esc_en) push_beat(esc_char, 1'b0, 1'b0);
                            push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                        end
                        2: push_beat($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0, 1'b0);
                        default: push_beat(content_char(), 1'b0, 1'b0);
                    endcase
                end
                push_beat(qt_char, 1'b0, 1'b0);
            end else begin
                for (int k = 0; k < len; k++) begin
                    if (esc_en && $urandom_range(0, 5) == 0) begin
                        push_beat(esc_char, 1'b0, 1'b0);
                        push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    end else begin
                        push_beat(content_char(), 1'b0, 1'b0);
                    end
                end
            end
        end
        case ($urandom_range(0, 3))
            0: push_beat(CH_LF, 1'b0, 1'b0);
            1: begin
                push_beat(CH_CR, 1'b0, 1'b0);
                push_beat(CH_LF, 1'b0, 1'b0);
            end
            2: push_beat(CH_CR, 1'b0, 1'b0);
            default: push_beat(CH_CR, 1'b0, 1'b1);
        endcase
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Power-on settings: doubled quotes, separators, CR/LF handling and restart.
        idle_rate = 4;
        push_beat(RST_QUOTE_BYTE, 1'b1, 1'b0);
        push_beat("a", 1'b0, 1'b0);
        push_beat(RST_QUOTE_BYTE, 1'b0, 1'b0);
        push_beat(RST_QUOTE_BYTE, 1'b0, 1'b0);
        push_beat(CH_LF, 1'b0, 1'b0);
        push_beat(RST_QUOTE_BYTE, 1'b0, 1'b0);
        push_beat(RST_SEPARATOR_BYTE, 1'b0, 1'b0);
        push_beat("x", 1'b0, 1'b0);
        push_beat(CH_CR, 1'b0, 1'b0);
        push_beat(CH_LF, 1'b0, 1'b0);
        push_beat(CH_CR, 1'b0, 1'b0);
        push_beat(CH_CR, 1'b0, 1'b1);
        push_beat(CH_LF, 1'b0, 1'b0);
        push_beat(CH_CR, 1'b0, 1'b0);
        push_beat(8'hff, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0);
        push_beat(CH_CR, 1'b0, 1'b0);
        push_beat("a", 1'b1, 1'b0);
        push_beat(RST_ESCAPE_BYTE, 1'b0, 1'b0);
        drain();

        // Escape equal to quote: inside quotes the escape meaning wins, so the field stays open.
        apply_config(RST_QUOTE_BYTE, RST_QUOTE_BYTE, RST_SEPARATOR_BYTE, 1'b1, 1'b1, 1'b1);
        push_beat(RST_QUOTE_BYTE, 1'b1, 1'b0);
        push_beat(RST_QUOTE_BYTE, 1'b0, 1'b0);
        push_beat("x", 1'b0, 1'b0);
        push_beat(CH_LF, 1'b0, 1'b0);
        drain();

        // The quoted state carries over after quoting is switched off.
        apply_config(RST_QUOTE_BYTE, RST_ESCAPE_BYTE, RST_SEPARATOR_BYTE, 1'b0, 1'b0, 1'b1);
        push_beat(RST_ESCAPE_BYTE, 1'b0, 1'b0);
        push_beat(RST_QUOTE_BYTE, 1'b0, 1'b0);
        push_beat(RST_QUOTE_BYTE, 1'b0, 1'b0);
        push_beat(RST_QUOTE_BYTE, 1'b0, 1'b0);
        push_beat(RST_ESCAPE_BYTE, 1'b0, 1'b0);
        push_beat(CH_CR, 1'b0, 1'b0);
        push_beat(RST_ESCAPE_BYTE, 1'b0, 1'b0);
        drain();

        apply_config(RST_QUOTE_BYTE, RST_ESCAPE_BYTE, RST_SEPARATOR_BYTE, 1'b0, 1'b0, 1'b0);
        push_beat(CH_LF, 1'b0, 1'b0);
        push_beat(RST_ESCAPE_BYTE, 1'b0, 1'b0);
        push_beat(CH_CR, 1'b0, 1'b0);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_config(RST_QUOTE_BYTE, RST_ESCAPE_BYTE, RST_SEPARATOR_BYTE,
                                1'b1, 1'b1, 1'b1);
                1: apply_config(8'h00, 8'hff, 8'h00, 1'b1, 1'b1, 1'b1);
                2: apply_config(8'hff, 8'h00, 8'hff, 1'b0, 1'b0, 1'b0);
                3: apply_config(RST_QUOTE_BYTE, RST_QUOTE_BYTE, RST_SEPARATOR_BYTE,
                                1'b1, 1'b1, 1'b1);
                default: apply_config(8'($urandom), 8'($urandom), 8'($urandom),
                                      1'($urandom), 1'($urandom), 1'($urandom));
            endcase
            case (p)
                1: idle_rate = 3;
                3, 7: idle_rate = 0;
                6: idle_rate = 20;
                default: idle_rate = 8;
            endcase
            beats_queued = 0;
            while (beats_queued < PHASE_BEATS) begin
                if ($urandom_range(0, 4) == 0)
                    push_beat(pick_char(), $urandom_range(0, 59) == 0,
                              $urandom_range(0, 7) == 0);
                else
                    push_record();
            end
            drain();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
